// ===== rtl/cdds_pkg.sv =====
// Shared types, codes and calendar helpers for the day stepper.
// No dependencies; used by the step unit, the core and the bench.
`timescale 1ns / 1ps

package cdds_pkg;

  // Command codes carried in the request word
  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_FWD  = 2'd1,
    CMD_BACK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  localparam logic [4:0] DAY_FIRST   = 5'd1;
  localparam logic [3:0] MONTH_FIRST = 4'd1;
  localparam logic [3:0] MONTH_LAST  = 4'd12;
  localparam logic [3:0] MONTH_FEB   = 4'd2;
  localparam logic [3:0] MONTH_APR   = 4'd4;
  localparam logic [3:0] MONTH_JUN   = 4'd6;
  localparam logic [3:0] MONTH_SEP   = 4'd9;
  localparam logic [3:0] MONTH_NOV   = 4'd11;
  localparam logic [4:0] LEN_LONG    = 5'd31;
  localparam logic [4:0] LEN_SHORT   = 5'd30;
  localparam logic [4:0] LEN_FEB     = 5'd28;
  localparam logic [4:0] LEN_FEB_LY  = 5'd29;
  localparam int unsigned RESET_YEAR = 1900;

  // Day and month of the stored date
  typedef struct packed {
    logic [4:0] day;
    logic [3:0] month;
  } dm_t;

  function automatic logic is_short_month(logic [3:0] m);
    return (m == MONTH_APR) || (m == MONTH_JUN) || (m == MONTH_SEP) || (m == MONTH_NOV);
  endfunction

  // Days in a month; leap set when the year is divisible by 4
  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    if (is_short_month(m)) begin
      len = LEN_SHORT;
    end else if (m == MONTH_FEB) begin
      len = leap ? LEN_FEB_LY : LEN_FEB;
    end else begin
      len = LEN_LONG;
    end
    return len;
  endfunction

  // Calendar check with a day that may reach 32 after an increment
  function automatic logic date_valid(logic [5:0] d, logic [3:0] m, logic leap);
    logic ok;
    if (d == 6'd0 || m < MONTH_FIRST || m > MONTH_LAST) begin
      ok = 1'b0;
    end else begin
      ok = (d <= {1'b0, month_len(m, leap)});
    end
    return ok;
  endfunction

endpackage

// ===== rtl/cdds_req_if.sv =====
// Request channel: valid/ready handshake with one command word.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

interface cdds_req_if #(
  parameter int YEAR_BITS  = 14,
  parameter int COUNT_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            command;
  logic [4:0]            load_day;
  logic [3:0]            load_month;
  logic [YEAR_BITS-1:0]  load_year;
  logic [COUNT_BITS-1:0] day_count;

  modport source (output valid, command, load_day, load_month, load_year, day_count,
                  input ready);
  modport sink   (input valid, command, load_day, load_month, load_year, day_count,
                  output ready);
endinterface

// ===== rtl/cdds_rsp_if.sv =====
// Response channel: valid/ready handshake with the stored date word.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps

interface cdds_rsp_if #(
  parameter int YEAR_BITS = 14
);
  logic                 valid;
  logic                 ready;
  logic [4:0]           cur_day;
  logic [3:0]           cur_month;
  logic [YEAR_BITS-1:0] cur_year;
  logic                 date_ok;

  modport source (output valid, cur_day, cur_month, cur_year, date_ok, input ready);
  modport sink   (input valid, cur_day, cur_month, cur_year, date_ok, output ready);
endinterface

// ===== rtl/cdds_step_unit.sv =====
// One-day step unit: moves a date forward or back by a single day.
// Depends on cdds_pkg for the date type and calendar helpers.
`timescale 1ns / 1ps

module cdds_step_unit #(
  parameter int YEAR_BITS = 14
) (
  input  cdds_pkg::dm_t        dm_i,
  input  logic [YEAR_BITS-1:0] year_i,
  input  logic                 back_i,
  output cdds_pkg::dm_t        dm_o,
  output logic [YEAR_BITS-1:0] year_o
);

  logic [5:0]           day_up;
  logic [5:0]           day_dn;
  logic [4:0]           month_up;
  logic [YEAR_BITS-1:0] year_dec;
  logic                 leap;

  assign leap     = (year_i[1:0] == 2'b00);
  assign day_up   = {1'b0, dm_i.day} + 6'd1;
  assign day_dn   = (dm_i.day == 5'd0) ? 6'd0 : ({1'b0, dm_i.day} - 6'd1);
  assign month_up = {1'b0, dm_i.month} + 5'd1;
  assign year_dec = year_i - YEAR_BITS'(1);

  always_comb begin
    dm_o   = dm_i;
    year_o = year_i;
    if (!back_i) begin
      // advance: roll into the next month, then the next year
      if (cdds_pkg::date_valid(day_up, dm_i.month, leap)) begin
        dm_o.day = day_up[4:0];
      end else begin
        dm_o.day = cdds_pkg::DAY_FIRST;
        if (month_up > {1'b0, cdds_pkg::MONTH_LAST}) begin
          dm_o.month = cdds_pkg::MONTH_FIRST;
          year_o     = year_i + YEAR_BITS'(1);
        end else begin
          dm_o.month = month_up[3:0];
        end
      end
    end else begin
      // retreat: fall back to the last day of the previous month
      if (cdds_pkg::date_valid(day_dn, dm_i.month, leap)) begin
        dm_o.day = day_dn[4:0];
      end else if (dm_i.month <= cdds_pkg::MONTH_FIRST ||
                   dm_i.month > (cdds_pkg::MONTH_LAST + 4'd1)) begin
        dm_o.month = cdds_pkg::MONTH_LAST;
        year_o     = year_dec;
        dm_o.day   = cdds_pkg::month_len(cdds_pkg::MONTH_LAST, year_dec[1:0] == 2'b00);
      end else begin
        dm_o.month = dm_i.month - 4'd1;
        dm_o.day   = cdds_pkg::month_len(dm_i.month - 4'd1, leap);
      end
    end
  end

endmodule

// ===== rtl/calendar_date_day_stepper_core.sv =====
// Top level of the calendar day stepper: date registers, step sequencer, output register.
// Depends on cdds_pkg, cdds_req_if, cdds_rsp_if and cdds_step_unit.
`timescale 1ns / 1ps

// Usage
//   req_i carries one command word: load a date, step forward day_count days,
//   or step back day_count days. An unused command leaves the date alone.
//   rsp_o returns one word per request: the stored date after the command and
//   a flag that tells whether it is a valid calendar date.
// Timing
//   An accepted request passes through the run state, where the single step unit
//   moves the date by one day per cycle, day_count times (no steps for a load or
//   an unused command), and then the done state, which writes the response register.
//   req_i.ready is high only while the sequencer is idle; a new word may be
//   taken while the previous response still waits in the output register.
// Reset
//   rst_ni clears the date to day 1, month 1, year 1900 (modulo the year width)
//   and empties the output register.
// Stall
//   If rsp_o.ready is low, the finished response holds and the sequencer waits
//   with its result until the output register frees up.

module calendar_date_day_stepper_core #(
  parameter int YEAR_BITS  = 14,
  parameter int COUNT_BITS = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdds_req_if.sink   req_i,
  cdds_rsp_if.source rsp_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  back_q, back_d;
  cdds_pkg::dm_t         dm_q, dm_d, dm_step;
  logic [YEAR_BITS-1:0]  year_q, year_d, year_step;
  logic                  req_fire;
  logic                  rsp_write;
  logic                  rsp_valid_q;
  logic [4:0]            rsp_day_q;
  logic [3:0]            rsp_month_q;
  logic [YEAR_BITS-1:0]  rsp_year_q;
  logic                  rsp_ok_q;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_write   = (state_q == ST_DONE) && (!rsp_valid_q || rsp_o.ready);

  cdds_step_unit #(
    .YEAR_BITS(YEAR_BITS)
  ) u_step (
    .dm_i   (dm_q),
    .year_i (year_q),
    .back_i (back_q),
    .dm_o   (dm_step),
    .year_o (year_step)
  );

  // Sequence: take a word, step once per cycle, then hand over the date
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    back_d  = back_q;
    dm_d    = dm_q;
    year_d  = year_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_RUN;
          count_d = '0;
          case (req_i.command)
            cdds_pkg::CMD_LOAD: begin
              dm_d.day   = req_i.load_day;
              dm_d.month = req_i.load_month;
              year_d     = req_i.load_year;
            end
            cdds_pkg::CMD_FWD: begin
              count_d = req_i.day_count;
              back_d  = 1'b0;
            end
            cdds_pkg::CMD_BACK: begin
              count_d = req_i.day_count;
              back_d  = 1'b1;
            end
            default: begin
              count_d = '0;
            end
          endcase
        end
      end
      ST_RUN: begin
        if (count_q == '0) begin
          state_d = ST_DONE;
        end else begin
          dm_d    = dm_step;
          year_d  = year_step;
          count_d = count_q - COUNT_BITS'(1);
        end
      end
      ST_DONE: begin
        if (rsp_write) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      back_q     <= 1'b0;
      dm_q.day   <= cdds_pkg::DAY_FIRST;
      dm_q.month <= cdds_pkg::MONTH_FIRST;
      year_q     <= YEAR_BITS'(cdds_pkg::RESET_YEAR);
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      back_q  <= back_d;
      dm_q    <= dm_d;
      year_q  <= year_d;
    end
  end

  // Hold the response word until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (rsp_write) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_write) begin
      rsp_day_q   <= dm_q.day;
      rsp_month_q <= dm_q.month;
      rsp_year_q  <= year_q;
      rsp_ok_q    <= cdds_pkg::date_valid({1'b0, dm_q.day}, dm_q.month,
                                          year_q[1:0] == 2'b00);
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.cur_day   = rsp_day_q;
  assign rsp_o.cur_month = rsp_month_q;
  assign rsp_o.cur_year  = rsp_year_q;
  assign rsp_o.date_ok   = rsp_ok_q;

endmodule

// ===== rtl/cdds_checker.sv =====
// Port-level checks for the day stepper core, attached by the bind below.
// Depends on calendar_date_day_stepper_core and its interfaces.
`timescale 1ns / 1ps

module cdds_checker #(
  parameter int YEAR_BITS = 14
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 req_valid_i,
  input logic                 req_ready_i,
  input logic                 rsp_valid_i,
  input logic                 rsp_ready_i,
  input logic [4:0]           rsp_day_i,
  input logic [3:0]           rsp_month_i,
  input logic [YEAR_BITS-1:0] rsp_year_i,
  input logic                 rsp_ok_i
);

  // A stalled response word stays offered
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // A stalled response word keeps its payload
  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_day_i) && $stable(rsp_month_i)
                                    && $stable(rsp_year_i) && $stable(rsp_ok_i))
    else $error("response payload changed while stalled");

  // One word at a time: busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while a word is in progress");

  // A fresh response leaves the sequencer idle
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> req_ready_i)
    else $error("response issued while sequencer still busy");

endmodule

bind calendar_date_day_stepper_core cdds_checker #(
  .YEAR_BITS(YEAR_BITS)
) u_cdds_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_day_i   (rsp_o.cur_day),
  .rsp_month_i (rsp_o.cur_month),
  .rsp_year_i  (rsp_o.cur_year),
  .rsp_ok_i    (rsp_o.date_ok)
);

// ===== bench/tb_top.sv =====
// Self-checking bench for calendar_date_day_stepper_core: a directed table, then random words.
// Depends on cdds_pkg, cdds_req_if, cdds_rsp_if and the core; predicts every date the table does not give.
`timescale 1ns / 1ps

module tb_top;

  localparam int YEAR_BITS  = 14;
  localparam int COUNT_BITS = 12;
  localparam logic [YEAR_BITS-1:0]  YEAR_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam bit TYPED   = 1'b1;
  localparam bit PREDICT = 1'b0;
  localparam int RANDOM_PER_PHASE = 384;
  localparam int DRAIN_LIMIT      = 60000;
  localparam int RESET_YEAR       = int'(cdds_pkg::RESET_YEAR);

  typedef struct packed {
    cdds_pkg::cmd_e        cmd;
    logic [4:0]            day;
    logic [3:0]            month;
    logic [YEAR_BITS-1:0]  year;
    logic [COUNT_BITS-1:0] count;
  } date_cmd_t;

  typedef struct packed {
    logic [4:0]           day;
    logic [3:0]           month;
    logic [YEAR_BITS-1:0] year;
    logic                 ok;
  } date_word_t;

  typedef struct packed {
    date_cmd_t  word;
    logic       typed;
    date_word_t date;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cdds_req_if #(.YEAR_BITS(YEAR_BITS), .COUNT_BITS(COUNT_BITS)) date_req ();
  cdds_rsp_if #(.YEAR_BITS(YEAR_BITS)) date_rsp ();

  calendar_date_day_stepper_core #(
    .YEAR_BITS (YEAR_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (date_req),
    .rsp_o (date_rsp)
  );

  // Date the bench believes is stored in the block
  logic [4:0]           cal_day;
  logic [3:0]           cal_month;
  logic [YEAR_BITS-1:0] cal_year;

  date_word_t pending_dates [$];
  plan_row_t  plan [$];
  int         send_gap_pct;
  int         rsp_gap_pct;
  int         fail_count;

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [4:0] days_in_month(int m, logic [YEAR_BITS-1:0] y);
    if (m == cdds_pkg::MONTH_APR || m == cdds_pkg::MONTH_JUN ||
        m == cdds_pkg::MONTH_SEP || m == cdds_pkg::MONTH_NOV) begin
      return cdds_pkg::LEN_SHORT;
    end else if (m == cdds_pkg::MONTH_FEB) begin
      return (y[1:0] == 2'b00) ? cdds_pkg::LEN_FEB_LY : cdds_pkg::LEN_FEB;
    end
    return cdds_pkg::LEN_LONG;
  endfunction

  function automatic bit date_is_real(int d, int m, logic [YEAR_BITS-1:0] y);
    if (d < 1 || d > 31 || m < 1 || m > 12) begin
      return 1'b0;
    end
    return d <= int'(days_in_month(m, y));
  endfunction

  // Advance the believed date by one day
  function automatic void step_day_fwd();
    int d;
    int m;
    d = int'(cal_day) + 1;
    m = int'(cal_month);
    if (!date_is_real(d, m, cal_year)) begin
      d = 1;
      m = m + 1;
      if (m < 1 || m > 12) begin
        m = 1;
        cal_year = cal_year + 1'b1;
      end
    end
    cal_day   = d[4:0];
    cal_month = m[3:0];
  endfunction

  // Move the believed date back one day, landing on the month's last day on a borrow
  function automatic void step_day_back();
    int d;
    int m;
    d = int'(cal_day) - 1;
    m = int'(cal_month);
    if (!date_is_real(d, m, cal_year)) begin
      m = m - 1;
      if (m < 1 || m > 12) begin
        m = 12;
        cal_year = cal_year - 1'b1;
      end
      d = int'(days_in_month(m, cal_year));
    end
    cal_day   = d[4:0];
    cal_month = m[3:0];
  endfunction

  // Apply one command word to the believed date and return the date word it yields
  function automatic date_word_t next_date(date_cmd_t w);
    date_word_t r;
    case (w.cmd)
      cdds_pkg::CMD_LOAD: begin
        cal_day   = w.day;
        cal_month = w.month;
        cal_year  = w.year;
      end
      cdds_pkg::CMD_FWD: begin
        repeat (w.count) step_day_fwd();
      end
      cdds_pkg::CMD_BACK: begin
        repeat (w.count) step_day_back();
      end
      default: begin
      end
    endcase
    r.day   = cal_day;
    r.month = cal_month;
    r.year  = cal_year;
    r.ok    = date_is_real(int'(cal_day), int'(cal_month), cal_year);
    return r;
  endfunction

  function automatic plan_row_t mk_row(cdds_pkg::cmd_e c, int d, int m, int y, int n,
                                       bit typed, int ed, int em, int ey, int eok);
    plan_row_t r;
    r.word  = '{cmd: c, day: d[4:0], month: m[3:0], year: y[YEAR_BITS-1:0],
                count: n[COUNT_BITS-1:0]};
    r.typed = typed;
    r.date  = '{day: ed[4:0], month: em[3:0], year: ey[YEAR_BITS-1:0], ok: eok[0]};
    return r;
  endfunction

  // Mostly well-formed dates and short steps; some garbage loads and a few long steps
  function automatic date_cmd_t random_word();
    date_cmd_t w;
    int pick;
    int m;
    w.day   = 5'($urandom);
    w.month = 4'($urandom);
    w.year  = YEAR_BITS'($urandom);
    pick = $urandom_range(99);
    if (pick < 82) begin
      w.count = COUNT_BITS'($urandom_range(15));
    end else if (pick < 97) begin
      w.count = COUNT_BITS'($urandom_range(400, 16));
    end else begin
      w.count = COUNT_BITS'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 12) begin
      w.cmd = cdds_pkg::CMD_LOAD;
      if ($urandom_range(99) < 25) begin
        w.year = ($urandom_range(1) != 0) ? YEAR_BITS'($urandom_range(3))
                                          : YEAR_MAX - YEAR_BITS'($urandom_range(3));
      end
      m = $urandom_range(12, 1);
      w.month = m[3:0];
      w.day   = 5'($urandom_range(int'(days_in_month(m, w.year)), 1));
    end else if (pick < 16) begin
      w.cmd = cdds_pkg::CMD_LOAD;
    end else if (pick < 56) begin
      w.cmd = cdds_pkg::CMD_FWD;
    end else if (pick < 96) begin
      w.cmd = cdds_pkg::CMD_BACK;
    end else begin
      w.cmd = cdds_pkg::CMD_NOP;
    end
    return w;
  endfunction

  // Offer one word after a random gap and hold it until the block takes it
  task automatic send_word(date_cmd_t w, bit typed, date_word_t typed_date);
    date_word_t predicted;
    while ($urandom_range(99) < send_gap_pct) begin
      date_req.valid = 1'b0;
      @(negedge clk_i);
    end
    date_req.command    = w.cmd;
    date_req.load_day   = w.day;
    date_req.load_month = w.month;
    date_req.load_year  = w.year;
    date_req.day_count  = w.count;
    date_req.valid      = 1'b1;
    predicted = next_date(w);
    do @(posedge clk_i); while (!date_req.ready);
    pending_dates.push_back(typed ? typed_date : predicted);
    @(negedge clk_i);
  endtask

  // Stall the response side at random
  always @(negedge clk_i) begin
    date_rsp.ready = ($urandom_range(99) >= rsp_gap_pct);
  end

  // Check each response word against the oldest expected date
  always @(posedge clk_i) begin : date_check
    date_word_t want;
    if (rst_ni && date_rsp.valid && date_rsp.ready) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected date word %0d/%0d/%0d ok=%0d", $time,
                 date_rsp.cur_day, date_rsp.cur_month, date_rsp.cur_year, date_rsp.date_ok);
        fail_count++;
      end else begin
        want = pending_dates.pop_front();
        if (date_rsp.cur_day !== want.day || date_rsp.cur_month !== want.month ||
            date_rsp.cur_year !== want.year || date_rsp.date_ok !== want.ok) begin
          $display("%0t: date mismatch exp %0d/%0d/%0d ok=%0d got %0d/%0d/%0d ok=%0d",
                   $time, want.day, want.month, want.year, want.ok,
                   date_rsp.cur_day, date_rsp.cur_month, date_rsp.cur_year,
                   date_rsp.date_ok);
          fail_count++;
        end
      end
    end
  end

  // Bound the whole run
  initial begin
    #500_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int drain_cycles;
    fail_count   = 0;
    send_gap_pct = 37;
    rsp_gap_pct  = 71;
    cal_day      = cdds_pkg::DAY_FIRST;
    cal_month    = cdds_pkg::MONTH_FIRST;
    cal_year     = YEAR_BITS'(cdds_pkg::RESET_YEAR);

    date_req.valid      = 1'b0;
    date_req.command    = cdds_pkg::CMD_NOP;
    date_req.load_day   = '0;
    date_req.load_month = '0;
    date_req.load_year  = '0;
    date_req.day_count  = '0;
    date_rsp.ready      = 1'b0;

    // Directed table: extremes, every command and the calendar corner cases
    plan.push_back(mk_row(cdds_pkg::CMD_NOP, 31, 15, YEAR_MAX, COUNT_MAX, TYPED,
                          1, 1, RESET_YEAR, 1));
    plan.push_back(mk_row(cdds_pkg::CMD_FWD, 0, 0, 0, 0, TYPED, 1, 1, RESET_YEAR, 1));
    plan.push_back(mk_row(cdds_pkg::CMD_BACK, 0, 0, 0, 0, TYPED, 1, 1, RESET_YEAR, 1));
    plan.push_back(mk_row(cdds_pkg::CMD_LOAD, 31, 12, YEAR_MAX, COUNT_MAX, TYPED,
                          31, 12, YEAR_MAX, 1));
    plan.push_back(mk_row(cdds_pkg::CMD_FWD, 0, 0, 0, 1, TYPED, 1, 1, 0, 1));
    plan.push_back(mk_row(cdds_pkg::CMD_BACK, 0, 0, 0, 1, TYPED, 31, 12, YEAR_MAX, 1));
    plan.push_back(mk_row(cdds_pkg::CMD_LOAD, 0, 0, 0, 0, TYPED, 0, 0, 0, 0));
    plan.push_back(mk_row(cdds_pkg::CMD_FWD, 0, 0, 0, 1, PREDICT, 0, 0, 0, 0));
    plan.push_back(mk_row(cdds_pkg::CMD_LOAD, 31, 15, YEAR_MAX, 0, TYPED,
                          31, 15, YEAR_MAX, 0));
    plan.push_back(mk_row(cdds_pkg::CMD_FWD, 0, 0, 0, 1, PREDICT, 0, 0, 0, 0));
    plan.push_back(mk_row(cdds_pkg::CMD_LOAD, 29, 2, 2000, 0, TYPED, 29, 2, 2000, 1));
    plan.push_back(mk_row(cdds_pkg::CMD_LOAD, 29, 2, 1901, 0, TYPED, 29, 2, 1901, 0));
    plan.push_back(mk_row(cdds_pkg::CMD_FWD, 0, 0, 0, 1, PREDICT, 0, 0, 0, 0));
    plan.push_back(mk_row(cdds_pkg::CMD_LOAD, 1, 3, 2004, 0, TYPED, 1, 3, 2004, 1));
    plan.push_back(mk_row(cdds_pkg::CMD_BACK, 0, 0, 0, 1, PREDICT, 0, 0, 0, 0));
    plan.push_back(mk_row(cdds_pkg::CMD_LOAD, 1, 3, 2003, 0, TYPED, 1, 3, 2003, 1));
    plan.push_back(mk_row(cdds_pkg::CMD_BACK, 0, 0, 0, 1, PREDICT, 0, 0, 0, 0));
    plan.push_back(mk_row(cdds_pkg::CMD_LOAD, 31, 4, 2000, 0, TYPED, 31, 4, 2000, 0));
    plan.push_back(mk_row(cdds_pkg::CMD_LOAD, 1, 1, 0, 0, TYPED, 1, 1, 0, 1));
    plan.push_back(mk_row(cdds_pkg::CMD_BACK, 0, 0, 0, 1, PREDICT, 0, 0, 0, 0));
    plan.push_back(mk_row(cdds_pkg::CMD_FWD, 0, 0, 0, COUNT_MAX, PREDICT, 0, 0, 0, 0));
    plan.push_back(mk_row(cdds_pkg::CMD_BACK, 0, 0, 0, COUNT_MAX, PREDICT, 0, 0, 0, 0));
    plan.push_back(mk_row(cdds_pkg::CMD_LOAD, 0, 5, 1999, 0, TYPED, 0, 5, 1999, 0));
    plan.push_back(mk_row(cdds_pkg::CMD_BACK, 0, 0, 0, 1, PREDICT, 0, 0, 0, 0));
    plan.push_back(mk_row(cdds_pkg::CMD_LOAD, 15, 0, 100, 0, TYPED, 15, 0, 100, 0));
    plan.push_back(mk_row(cdds_pkg::CMD_BACK, 0, 0, 0, 1, PREDICT, 0, 0, 0, 0));
    plan.push_back(mk_row(cdds_pkg::CMD_LOAD, 20, 13, 5, 0, TYPED, 20, 13, 5, 0));
    plan.push_back(mk_row(cdds_pkg::CMD_FWD, 0, 0, 0, 1, PREDICT, 0, 0, 0, 0));

    // Hold reset low, then release it on a falling edge
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      send_word(plan[i].word, plan[i].typed, plan[i].date);
    end

    // Random words in three phases with different send and response gaps
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct = 37;
          rsp_gap_pct  = 71;
        end
        1: begin
          send_gap_pct = 71;
          rsp_gap_pct  = 37;
        end
        default: begin
          send_gap_pct = 0;
          rsp_gap_pct  = 0;
        end
      endcase
      repeat (RANDOM_PER_PHASE) begin
        send_word(random_word(), PREDICT, '0);
      end
    end
    date_req.valid = 1'b0;

    // Drain outstanding words, then watch for strays
    drain_cycles = 0;
    while (pending_dates.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    if (pending_dates.size() != 0) begin
      $display("%0t: %0d expected date words never arrived", $time, pending_dates.size());
      fail_count += pending_dates.size();
    end
    repeat (16) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
